>>> src/tgdg_pkg.sv
// Package for the toroidal growth-diffusion grid.
// Types, constants and request codes shared by the front, queue and engine.
`default_nettype none
package tgdg_pkg;
    localparam int MaxSide  = 64;
    localparam int Cells    = MaxSide * MaxSide;
    localparam int AddrW    = $clog2(Cells);
    localparam int SideW    = 7;
    localparam int OneQ16   = 65536;
    localparam int Coef005  = 3277;
    localparam int MaxWeight = 16384;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_READ    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_SIDE   = 2'd0,
        CFG_LAYERS = 2'd1,
        CFG_WEIGHT = 2'd2
    } cfg_idx_t;

    // classified request passed from the front to the engine
    typedef struct packed {
        mode_t             op;
        logic signed [31:0] s;
        logic signed [31:0] r;
        logic [11:0]       addr;
    } req_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_RDW, ST_READOUT,
        ST_G_MUL, ST_G_DIV, ST_G_Q, ST_G_P, ST_G_P2, ST_G_X, ST_G_X2, ST_G_WR,
        ST_D_CEN, ST_D_UP, ST_D_DN, ST_D_LF, ST_D_RT, ST_D_SUM, ST_D_MUL,
        ST_D_ACC, ST_D_WR, ST_C_RD, ST_C_RDW, ST_C_WR
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

>>> src/tgdg_front.sv
// Front end: accepts stream requests and classifies them into the queue.
// Depends on tgdg_pkg.
`default_nettype none
module tgdg_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [1:0]     s_tuser,
    input  wire logic [79:0]    s_tdata,
    output logic                q_valid,
    input  wire logic           q_ready,
    output tgdg_pkg::req_t      q_req
);
    import tgdg_pkg::*;
    req_t req_reg;
    logic vld_reg;

    assign s_tready = !vld_reg || q_ready;
    assign q_valid  = vld_reg;
    assign q_req    = req_reg;

    // one-entry skid register; mode 3 requests are dropped here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= s_tvalid && (mode_t'(s_tuser) != MODE_NONE);
        end
        if (s_tready) begin
            req_reg.op   <= mode_t'(s_tuser);
            req_reg.s    <= s_tdata[31:0];
            req_reg.r    <= s_tdata[63:32];
            req_reg.addr <= s_tdata[75:64];
        end
    end
endmodule
`default_nettype wire

>>> src/tgdg_queue.sv
// Two-entry request queue between the front end and the engine.
// Depends on tgdg_pkg.
`default_nettype none
module tgdg_queue (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  tgdg_pkg::req_t in_req,
    output logic           out_valid,
    input  wire logic      out_ready,
    output tgdg_pkg::req_t out_req
);
    import tgdg_pkg::*;
    req_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_req   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wp_reg] <= in_req;
    end
endmodule
`default_nettype wire

>>> src/tgdg_div.sv
// Restoring divider, one quotient bit per cycle, signed 49/33 operands.
// Depends on tgdg_pkg.
`default_nettype none
module tgdg_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [48:0] num,
    input  wire logic signed [32:0] den,
    output logic                    busy,
    output logic signed [48:0]      quo
);
    import tgdg_pkg::*;
    logic [48:0] n_reg, q_reg;
    logic [49:0] rem_reg;
    logic [32:0] d_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic [49:0] trial;

    assign busy = cnt_reg != 6'd0;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign trial = {rem_reg[48:0], n_reg[48]} - {17'd0, d_reg};

    // shift one numerator bit in per cycle, truncating toward zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (start) begin
            cnt_reg <= 6'd49;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
        if (start) begin
            n_reg   <= num[48] ? 49'(-num) : 49'(num);
            d_reg   <= den[32] ? 33'(-den) : 33'(den);
            neg_reg <= num[48] ^ den[32];
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy) begin
            n_reg <= {n_reg[47:0], 1'b0};
            if (!trial[49]) begin
                rem_reg <= trial;
                q_reg   <= {q_reg[47:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[48:0], n_reg[48]};
                q_reg   <= {q_reg[47:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> src/tgdg_engine.sv
// Engine: grid memory, growth step with divider, diffusion and copy sweeps.
// Depends on tgdg_pkg and tgdg_div.
`default_nettype none
module tgdg_engine (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  tgdg_pkg::req_t       q_req,
    input  wire logic [6:0]      side_in_use,
    input  wire logic [15:0]     layer_count,
    input  wire logic [14:0]     diffusion_weight,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [48:0]          m_tdata
);
    import tgdg_pkg::*;

    logic signed [31:0] grid_mem [Cells];
    logic signed [31:0] scr_mem  [Cells];
    logic signed [31:0] grd_q_reg, scr_q_reg;

    state_t state_reg, state_next;
    logic [AddrW-1:0] cpos_reg, cpos_next, idx_reg, idx_next;
    logic [15:0] lpos_reg, lpos_next;
    logic [5:0]  row_reg, row_next, col_reg, col_next;
    logic [AddrW:0] clr_reg, clr_next;
    req_t req_reg, req_next;
    logic signed [31:0] x_reg, x_next, q_reg, q_next, p_reg, p_next;
    logic signed [33:0] sum_reg, sum_next;
    logic signed [65:0] m1_reg, m1_next, m2_reg, m2_next;
    logic obuf_v_reg;
    logic [48:0] obuf_reg, obuf_next;
    logic obuf_load;

    logic [AddrW-1:0] g_raddr, g_waddr;
    logic g_we;
    logic signed [31:0] g_wdata;
    logic [AddrW-1:0] s_addr;
    logic s_we;

    logic div_start, div_busy;
    logic signed [48:0] div_quo;
    logic signed [32:0] den;

    logic [SideW-1:0] n;
    logic [12:0] total;
    logic [5:0]  nm1;
    logic [14:0] a;
    logic signed [17:0] c;
    logic done;

    always_comb begin
        n = (side_in_use < 7'd3) ? 7'd3 : ((side_in_use > 7'(MaxSide)) ? 7'(MaxSide) : side_in_use);
        nm1 = 6'(n - 7'd1);
        total = 13'(n) * 13'(n);
        a = (diffusion_weight > 15'(MaxWeight)) ? 15'(MaxWeight) : diffusion_weight;
        c = 18'sd65536 - $signed({1'b0, a, 2'b00});
        done = lpos_reg >= layer_count;
    end

    // row/column to flat address
    function automatic logic [AddrW-1:0] rc(input logic [5:0] rr, input logic [5:0] cc,
                                            input logic [6:0] nn);
        return AddrW'(rr * nn + 13'(cc));
    endfunction

    function automatic logic signed [32:0] r_ext(input logic signed [31:0] v);
        return 33'(v);
    endfunction

    tgdg_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({r_ext(req_reg.r), 16'd0}), .den(den), .busy(div_busy), .quo(div_quo)
    );

    // memories
    always_ff @(posedge aclk) begin
        if (g_we) grid_mem[g_waddr] <= g_wdata;
        grd_q_reg <= grid_mem[g_raddr];
        if (s_we) scr_mem[s_addr] <= g_wdata;
        scr_q_reg <= scr_mem[s_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            cpos_reg   <= '0;
            lpos_reg   <= '0;
            clr_reg    <= '0;
            obuf_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cpos_reg  <= cpos_next;
            lpos_reg  <= lpos_next;
            clr_reg   <= clr_next;
            if (obuf_load) obuf_v_reg <= 1'b1;
            else if (m_tready) obuf_v_reg <= 1'b0;
        end
        idx_reg <= idx_next; row_reg <= row_next; col_reg <= col_next;
        req_reg <= req_next; x_reg <= x_next; q_reg <= q_next; p_reg <= p_next;
        sum_reg <= sum_next; m1_reg <= m1_next; m2_reg <= m2_next;
        if (obuf_load) obuf_reg <= obuf_next;
    end

    assign m_tvalid = obuf_v_reg;
    assign m_tdata  = obuf_reg;

    always_comb begin
        state_next = state_reg;
        cpos_next = cpos_reg; lpos_next = lpos_reg; clr_next = clr_reg;
        idx_next = idx_reg; row_next = row_reg; col_next = col_reg;
        req_next = req_reg; x_next = x_reg; q_next = q_reg; p_next = p_reg;
        sum_next = sum_reg; m1_next = m1_reg; m2_next = m2_reg;
        obuf_load = 1'b0; obuf_next = obuf_reg;
        q_ready = 1'b0;
        g_raddr = idx_reg; g_waddr = idx_reg; g_we = 1'b0; g_wdata = x_reg;
        s_addr = idx_reg; s_we = 1'b0;
        div_start = 1'b0;
        den = 33'(m1_reg >>> 16) + 33'sd65536;
        case (state_reg)
            // clearing pass: every cell back to 1.0
            ST_CLEAR: begin
                g_we = 1'b1; g_waddr = clr_reg[AddrW-1:0]; g_wdata = 32'sd65536;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AddrW+1)'(Cells - 1)) begin
                    clr_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                q_ready = !obuf_v_reg || m_tready;
                if (q_valid && q_ready) begin
                    req_next = q_req;
                    case (q_req.op)
                        MODE_READ: begin
                            g_raddr = q_req.addr;
                            state_next = ST_RDW;
                        end
                        MODE_LOAD: begin
                            if (!done) begin
                                idx_next = (13'(cpos_reg) >= total) ? '0 : cpos_reg;
                                g_raddr = idx_next;
                                state_next = ST_RD;
                            end
                        end
                        MODE_RESTART: begin
                            cpos_next = '0; lpos_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            // keep the read address so the data is still there at readout
            ST_RDW: begin
                g_raddr = req_reg.addr;
                state_next = ST_READOUT;
            end
            ST_READOUT: begin
                obuf_load = 1'b1;
                obuf_next = {done, lpos_reg,
                             (13'(req_reg.addr) < total) ? grd_q_reg : 32'sd0};
                state_next = ST_IDLE;
            end
            ST_RD: state_next = ST_G_MUL;
            ST_G_MUL: begin
                x_next = grd_q_reg;
                m1_next = 66'(grd_q_reg) * 66'sd3277;
                m2_next = 66'(req_reg.s) * 66'(grd_q_reg);
                state_next = ST_G_DIV;
            end
            ST_G_DIV: begin
                if (den == 33'sd0) begin
                    q_next = (req_reg.r > 0) ? 32'sh7fffffff :
                             ((req_reg.r < 0) ? 32'sh80000000 : 32'sd0);
                    state_next = ST_G_P;
                end else begin
                    div_start = 1'b1;
                    state_next = ST_G_Q;
                end
            end
            ST_G_Q: if (!div_busy) begin
                q_next = sat32(66'(div_quo));
                state_next = ST_G_P;
            end
            ST_G_P: begin
                p_next = sat32(m2_reg >>> 16);
                q_next = sat32(66'sd65536 + 66'(q_reg));
                state_next = ST_G_X;
            end
            ST_G_X: begin
                m1_next = 66'(p_reg) * 66'(q_reg);
                state_next = ST_G_X2;
            end
            ST_G_X2: begin
                x_next = sat32(m1_reg >>> 16);
                state_next = ST_G_WR;
            end
            ST_G_WR: begin
                g_we = 1'b1;
                if (13'(idx_reg) + 13'd1 >= total) begin
                    row_next = '0; col_next = '0; idx_next = '0;
                    state_next = ST_D_CEN;
                end else begin
                    cpos_next = idx_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            // diffusion sweep: five reads per cell into scratch, read data registered
            ST_D_CEN: begin
                g_raddr = rc(row_reg, col_reg, n);
                state_next = ST_D_UP;
            end
            ST_D_UP: begin
                x_next = grd_q_reg;
                g_raddr = rc((row_reg == 6'd0) ? nm1 : row_reg - 6'd1, col_reg, n);
                state_next = ST_D_DN;
            end
            ST_D_DN: begin
                sum_next = 34'(grd_q_reg);
                g_raddr = rc((row_reg == nm1) ? 6'd0 : row_reg + 6'd1, col_reg, n);
                state_next = ST_D_LF;
            end
            ST_D_LF: begin
                sum_next = sum_reg + 34'(grd_q_reg);
                g_raddr = rc(row_reg, (col_reg == 6'd0) ? nm1 : col_reg - 6'd1, n);
                state_next = ST_D_RT;
            end
            ST_D_RT: begin
                sum_next = sum_reg + 34'(grd_q_reg);
                g_raddr = rc(row_reg, (col_reg == nm1) ? 6'd0 : col_reg + 6'd1, n);
                state_next = ST_D_SUM;
            end
            ST_D_SUM: begin
                sum_next = sum_reg + 34'(grd_q_reg);
                state_next = ST_D_MUL;
            end
            ST_D_MUL: begin
                m1_next = 66'(c) * 66'(x_reg);
                state_next = ST_D_ACC;
            end
            ST_D_ACC: begin
                m2_next = 66'($signed({1'b0, a})) * 66'(sum_reg);
                state_next = ST_D_WR;
            end
            ST_D_WR: begin
                s_we = 1'b1;
                s_addr = rc(row_reg, col_reg, n);
                g_wdata = sat32((m1_reg + m2_reg) >>> 16);
                state_next = ST_D_CEN;
                if (col_reg == nm1) begin
                    col_next = '0;
                    row_next = row_reg + 6'd1;
                    if (row_reg == nm1) begin
                        idx_next = '0;
                        state_next = ST_C_RD;
                    end
                end else begin
                    col_next = col_reg + 6'd1;
                end
            end
            // copy scratch back into the grid
            ST_C_RD: state_next = ST_C_RDW;
            ST_C_RDW: state_next = ST_C_WR;
            ST_C_WR: begin
                g_we = 1'b1; g_wdata = scr_q_reg;
                if (13'(idx_reg) + 13'd1 >= total) begin
                    cpos_next = '0;
                    if (lpos_reg != 16'hffff) lpos_next = lpos_reg + 16'd1;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_C_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> src/toroidal_growth_diffusion_grid.sv
// Top level of the toroidal growth-diffusion grid.
// Depends on tgdg_pkg, tgdg_front, tgdg_queue and tgdg_engine.
//   channel  | direction | contents
//   s_       | in        | tuser: mode; tdata: scale_factor, growth_term, cell_address
//   m_       | out       | tdata: cell_value, layers_done, finished
//   cfg_     | in        | register index and write data
// A read goes through a registered memory read; a load runs the divider unless its
// denominator is zero; the last load of a layer adds a stencil sweep over every cell and a copy back of each.
// After reset and restart a clearing pass over all 4096 cells runs before requests.
// Requests queue two deep behind the front register; a held result stalls the engine.
`default_nettype none
module toroidal_growth_diffusion_grid (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // mode
    input  wire logic [79:0] s_tdata,   // scale_factor, growth_term, cell_address
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // cell_value, layers_done, finished, zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import tgdg_pkg::*;
    logic f_valid, f_ready, e_valid, e_ready;
    req_t f_req, e_req;
    logic [6:0]  side_reg;
    logic [15:0] layers_reg;
    logic [14:0] weight_reg;
    logic [48:0] e_tdata;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {7'd0, e_tdata};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= 7'd64; layers_reg <= 16'd1; weight_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SIDE:   side_reg   <= cfg_data[6:0];
                CFG_LAYERS: layers_reg <= cfg_data;
                CFG_WEIGHT: weight_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    tgdg_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tuser(s_tuser), .s_tdata(s_tdata),
        .q_valid(f_valid), .q_ready(f_ready), .q_req(f_req)
    );
    tgdg_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_valid(f_valid), .in_ready(f_ready),
        .in_req(f_req), .out_valid(e_valid), .out_ready(e_ready), .out_req(e_req)
    );
    tgdg_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .q_valid(e_valid), .q_ready(e_ready),
        .q_req(e_req), .side_in_use(side_reg), .layer_count(layers_reg),
        .diffusion_weight(weight_reg), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(e_tdata)
    );
endmodule
`default_nettype wire
